@@ design/grid_region_perimeter_edges_defines.svh @@
// Assertion macros for the grid region perimeter edge block.
`ifndef GRID_REGION_PERIMETER_EDGES_DEFINES_SVH
`define GRID_REGION_PERIMETER_EDGES_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GRPE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GRPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/grpe_pkg.sv @@
// Shared types and constants for the grid region perimeter edge block.
package grpe_pkg;

  localparam int unsigned MAX_COLS_DEF = 63;

  localparam int unsigned ROWS_W      = 11;
  localparam int unsigned COLS_W      = 6;
  localparam int unsigned ROW_CNT_W   = 10;
  localparam int unsigned CELL_W      = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [ROWS_W-1:0] ROW_LIMIT    = 11'd1024;
  localparam logic [ROWS_W-1:0] ROWS_RESET   = 11'd32;
  localparam logic [COLS_W-1:0] COLS_RESET   = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_ROWS = 2'd0,
    CFG_NUM_COLS = 2'd1
  } grpe_cfg_idx_e;

  // One beat of work for the edge stage: a real cell or a flush step.
  typedef struct packed {
    logic emit;
    logic top_ok;
    logic below_known;
    logic last;
    logic filled;
  } grpe_item_t;

  typedef struct packed {
    logic flushing;
    logic item_valid;
  } grpe_front_st_t;

endpackage

@@ design/grpe_line.sv @@
// Shift line of inside bits with a programmable insertion point and fixed output taps.
module grpe_line #(
  parameter int unsigned DEPTH = grpe_pkg::MAX_COLS_DEF,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic [IW-1:0] ins_idx_i,
  input  logic          din_i,
  output logic          tap0_o,
  output logic          tap1_o
);

  logic [DEPTH-1:0] line_q;
  logic [DEPTH-1:0] line_d;
  logic [DEPTH:0]   line_ext;

  assign line_ext = {1'b0, line_q};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      line_d[i] = (IW'(i) == ins_idx_i) ? din_i : line_ext[i+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      line_q <= line_d;
    end
  end

  assign tap0_o = line_ext[0];
  assign tap1_o = line_ext[1];

endmodule

@@ design/grpe_front.sv @@
// Raster counters, flush sequencer and input register.
module grpe_front #(
  parameter int unsigned MAX_COLS = grpe_pkg::MAX_COLS_DEF,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                restart_i,
  input  logic [grpe_pkg::ROWS_W-1:0]         rows_eff_i,
  input  logic [grpe_pkg::COLS_W-1:0]         cols_eff_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] cell_value
  input  logic [grpe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                item_take_i,
  output grpe_pkg::grpe_item_t                item_o,
  output logic [CW-1:0]                       col_o,
  output grpe_pkg::grpe_front_st_t            status_o
);

  localparam int unsigned CMP_W = grpe_pkg::COLS_W + 1;

  logic [grpe_pkg::ROW_CNT_W-1:0] row_q, row_d;
  logic [CW-1:0]                  col_q, col_d;
  logic                           flush_q, flush_d;
  logic [CW-1:0]                  fcol_q, fcol_d;
  logic                           ftop_q, ftop_d;
  logic                           ivalid_q, ivalid_d;
  grpe_pkg::grpe_item_t           item_q, item_d;
  logic [CW-1:0]                  icol_q, icol_d;

  logic                           load;
  logic                           in_acc;
  logic                           row_last;
  logic                           col_last;
  logic                           fcol_last;
  logic [grpe_pkg::ROWS_W-1:0]    row_plus;
  logic [CMP_W-1:0]               cols_cmp;

  assign load          = !ivalid_q || item_take_i;
  assign s_axis_tready = !flush_q && load;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign row_plus  = {1'b0, row_q} + 11'd1;
  assign cols_cmp  = {1'b0, cols_eff_i};
  assign row_last  = (row_plus == rows_eff_i);
  assign col_last  = ((CMP_W'(col_q) + 7'd1) == cols_cmp);
  assign fcol_last = ((CMP_W'(fcol_q) + 7'd1) == cols_cmp);

  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    flush_d  = flush_q;
    fcol_d   = fcol_q;
    ftop_d   = ftop_q;
    ivalid_d = ivalid_q;
    item_d   = item_q;
    icol_d   = icol_q;

    if (load) begin
      ivalid_d = in_acc || flush_q;
    end

    if (in_acc) begin
      item_d.emit        = (row_q != '0);
      item_d.top_ok      = (row_q > 10'd1);
      item_d.below_known = 1'b1;
      item_d.last        = 1'b0;
      item_d.filled      = |s_axis_tdata;
      icol_d             = col_q;
      if (row_last && col_last) begin
        row_d   = '0;
        col_d   = '0;
        flush_d = 1'b1;
        fcol_d  = '0;
        ftop_d  = (row_q != '0);
      end else if (col_last) begin
        col_d = '0;
        row_d = row_q + 10'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (flush_q && load) begin
      item_d.emit        = 1'b1;
      item_d.top_ok      = ftop_q;
      item_d.below_known = 1'b0;
      item_d.last        = fcol_last;
      item_d.filled      = 1'b0;
      icol_d             = fcol_q;
      if (fcol_last) begin
        flush_d = 1'b0;
      end else begin
        fcol_d = fcol_q + CW'(1);
      end
    end

    if (restart_i) begin
      row_d   = '0;
      col_d   = '0;
      flush_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      flush_q  <= 1'b0;
      fcol_q   <= '0;
      ftop_q   <= 1'b0;
      ivalid_q <= 1'b0;
    end else begin
      row_q    <= row_d;
      col_q    <= col_d;
      flush_q  <= flush_d;
      fcol_q   <= fcol_d;
      ftop_q   <= ftop_d;
      ivalid_q <= ivalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    icol_q <= icol_d;
  end

  assign item_o              = item_q;
  assign col_o               = icol_q;
  assign status_o.flushing   = flush_q;
  assign status_o.item_valid = ivalid_q;

endmodule

@@ design/grpe_emit.sv @@
// Row lines, neighbor window, edge flags and output register.
module grpe_emit #(
  parameter int unsigned MAX_COLS = grpe_pkg::MAX_COLS_DEF,
  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [grpe_pkg::COLS_W-1:0]         cols_eff_i,
  input  grpe_pkg::grpe_item_t                item_i,
  input  logic [CW-1:0]                       col_i,
  input  logic                                item_valid_i,
  output logic                                item_take_o,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] edge_right, [1] edge_top, [2] edge_left, [3] edge_bottom, [7:4] zero
  output logic [grpe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int unsigned CMP_W = grpe_pkg::COLS_W + 1;

  logic                        out_free;
  logic                        take;
  logic [grpe_pkg::COLS_W-1:0] cols_m1;
  logic [CW-1:0]               ins_idx;
  logic                        a0, a1, b0;
  logic                        left_q;
  logic [3:0]                  flags;
  logic                        self_in;
  logic                        right_ok;
  logic                        out_valid_q;
  logic [3:0]                  flags_q;
  logic                        last_q;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign take        = item_valid_i && (!item_i.emit || out_free);
  assign item_take_o = take;

  assign cols_m1 = cols_eff_i - 6'd1;
  assign ins_idx = cols_m1[CW-1:0];

  grpe_line #(.DEPTH(MAX_COLS)) u_line_cur (
    .clk_i     (clk_i),
    .shift_i   (take),
    .ins_idx_i (ins_idx),
    .din_i     (item_i.filled),
    .tap0_o    (a0),
    .tap1_o    (a1)
  );

  grpe_line #(.DEPTH(MAX_COLS)) u_line_old (
    .clk_i     (clk_i),
    .shift_i   (take),
    .ins_idx_i (ins_idx),
    .din_i     (a0),
    .tap0_o    (b0),
    .tap1_o    ()
  );

  always_ff @(posedge clk_i) begin
    if (take) begin
      left_q <= a0;
    end
  end

  assign self_in  = a0;
  assign right_ok = ((CMP_W'(col_i) + 7'd1) < {1'b0, cols_eff_i});

  assign flags[0] = self_in && right_ok && !a1;
  assign flags[1] = self_in && item_i.top_ok && !b0;
  assign flags[2] = self_in && (col_i != '0) && !left_q;
  assign flags[3] = self_in && item_i.below_known && !item_i.filled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= take && item_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.emit) begin
      flags_q <= flags;
      last_q  <= item_i.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, flags_q};
  assign m_axis_tlast  = last_q;

endmodule

@@ design/grid_region_perimeter_edges.sv @@
// Four-neighbor perimeter edge flags over a raster grid of cells.
// A row r > 0 cell yields the result for the cell above, via input then output register.
// Throughput: one cell per cycle unless the output stalls, set by the single edge stage.
// The last grid cell adds num_cols results, one per cycle unless stalled; input held off.
// Reset: row and column counters clear, num_rows and num_cols return to 32,
// row line contents stay undefined until written by the grid.
`include "grid_region_perimeter_edges_defines.svh"

module grid_region_perimeter_edges #(
  parameter int unsigned MAX_COLS = grpe_pkg::MAX_COLS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [grpe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [grpe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] cell_value
  input  logic [grpe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] edge_right, [1] edge_top, [2] edge_left, [3] edge_bottom, [7:4] zero
  output logic [grpe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [grpe_pkg::ROWS_W-1:0] num_rows_q;
  logic [grpe_pkg::COLS_W-1:0] num_cols_q;
  logic [grpe_pkg::ROWS_W-1:0] rows_eff;
  logic [grpe_pkg::COLS_W-1:0] cols_eff;
  logic                        restart;

  grpe_pkg::grpe_item_t        item;
  logic [CW-1:0]               item_col;
  logic                        item_take;
  grpe_pkg::grpe_front_st_t    front_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= grpe_pkg::ROWS_RESET;
      num_cols_q <= grpe_pkg::COLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        grpe_pkg::CFG_NUM_ROWS: num_rows_q <= cfg_data_i;
        grpe_pkg::CFG_NUM_COLS: num_cols_q <= cfg_data_i[grpe_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && ((cfg_idx_i == grpe_pkg::CFG_NUM_ROWS) ||
                                (cfg_idx_i == grpe_pkg::CFG_NUM_COLS));

  always_comb begin
    if (num_rows_q == '0) begin
      rows_eff = 11'd1;
    end else if (num_rows_q > grpe_pkg::ROW_LIMIT) begin
      rows_eff = grpe_pkg::ROW_LIMIT;
    end else begin
      rows_eff = num_rows_q;
    end
    if (num_cols_q == '0) begin
      cols_eff = 6'd1;
    end else if (num_cols_q > grpe_pkg::COLS_W'(MAX_COLS)) begin
      cols_eff = grpe_pkg::COLS_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols_q;
    end
  end

  grpe_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .rows_eff_i    (rows_eff),
    .cols_eff_i    (cols_eff),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .item_take_i   (item_take),
    .item_o        (item),
    .col_o         (item_col),
    .status_o      (front_st)
  );

  grpe_emit #(.MAX_COLS(MAX_COLS)) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cols_eff_i    (cols_eff),
    .item_i        (item),
    .col_i         (item_col),
    .item_valid_i  (front_st.item_valid),
    .item_take_o   (item_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `GRPE_ASSERT_NOW(a_flush_blocks_input, front_st.flushing, !s_axis_tready, "input taken during flush")
  `GRPE_ASSERT_NOW(a_flush_after_beat, $rose(front_st.flushing), $past(s_axis_tvalid && s_axis_tready), "flush started without a beat")
  `GRPE_ASSERT_NEXT(a_beat_loads_item, s_axis_tvalid && s_axis_tready, front_st.item_valid, "accepted beat not held")

endmodule
